[src/ucdscan_pkg.sv]
// ----------------------------------------------------------------------------
// ucdscan_pkg
// Types and constants for the configuration descriptor endpoint scanner.
// ----------------------------------------------------------------------------
package ucdscan_pkg;

    localparam int unsigned BUFFER_BYTES = 256;

    localparam logic [15:0] POS_TOTAL_LO    = 16'd2;
    localparam logic [15:0] POS_TOTAL_HI    = 16'd3;
    localparam logic [15:0] POS_FIRST_DESC  = 16'd9;
    localparam logic [15:0] POS_MAX         = 16'hFFFF;

    localparam logic [15:0] OFF_TYPE        = 16'd1;
    localparam logic [15:0] OFF_ADDRESS     = 16'd2;
    localparam logic [15:0] OFF_ATTRIBUTES  = 16'd3;
    localparam logic [15:0] OFF_PACKET_LO   = 16'd4;
    localparam logic [15:0] OFF_PACKET_HI   = 16'd5;

    localparam logic [7:0]  DESC_TYPE_ENDPOINT = 8'h05;
    localparam logic [7:0]  ATTR_TYPE_MASK     = 8'h03;
    localparam logic [7:0]  ATTR_TYPE_BULK     = 8'h02;
    localparam int unsigned ADDR_DIR_BIT       = 7;
    localparam logic [7:0]  ADDR_NUMBER_MASK   = 8'h0F;

    localparam logic [15:0] RESET_PACKET = 16'd512;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } item_t;

    typedef struct packed {
        logic [3:0]  in_endpoint;
        logic [15:0] in_max_packet;
        logic [3:0]  out_endpoint;
        logic [15:0] out_max_packet;
        logic        scan_done;
        logic        malformed;
    } result_t;

endpackage

[src/usb_config_descriptor_endpoint_scan_top.sv]
// ----------------------------------------------------------------------------
// usb_config_descriptor_endpoint_scan_top
// Walks a configuration descriptor set byte by byte and reports the last
// bulk IN and bulk OUT endpoints with their maximum packet sizes.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------
//   item     | item_valid / item_stall    | item_t   (data_byte, first_byte)
//   result   | result_valid / result_stall| result_t (endpoints, flags)
//
// One item per cycle while the result side does not stall; each item
// passes through the input register and then the result register.
// The scan state is updated as an item moves into the result register.
// Reset clears the walk and sets both packet sizes to 512.
// A stalled result holds both stages; item_stall follows result_stall.
// ----------------------------------------------------------------------------
module usb_config_descriptor_endpoint_scan_top #(
    parameter int unsigned BUFFER_BYTES = ucdscan_pkg::BUFFER_BYTES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  ucdscan_pkg::item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output ucdscan_pkg::result_t result
);
    import ucdscan_pkg::*;

    localparam logic [15:0] BUF_LIMIT = 16'(BUFFER_BYTES);

    logic        in_valid_reg;
    item_t       in_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        advance;
    logic        take;

    logic [15:0] pos_reg, pos_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] start_reg, start_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  dtype_reg, dtype_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  attr_reg, attr_next;
    logic [7:0]  psl_reg, psl_next;
    logic [3:0]  in_ep_reg, in_ep_next;
    logic [15:0] in_pkt_reg, in_pkt_next;
    logic [3:0]  out_ep_reg, out_ep_next;
    logic [15:0] out_pkt_reg, out_pkt_next;
    logic        done_reg, done_next;
    logic        bad_reg, bad_next;

    assign advance      = !out_valid_reg || !result_stall;
    assign take         = in_valid_reg && advance;
    assign item_stall   = in_valid_reg && !advance;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        logic [15:0] pos;
        logic [15:0] limit;
        logic [15:0] limit_hi;
        logic [15:0] off;
        logic [7:0]  b;
        logic        do_open;
        logic [16:0] desc_end;

        b        = in_reg.data_byte;
        pos      = in_reg.first_byte ? '0 : pos_reg;
        total_next = in_reg.first_byte ? '0 : total_reg;
        start_next = in_reg.first_byte ? POS_FIRST_DESC : start_reg;
        len_next   = in_reg.first_byte ? '0 : len_reg;
        dtype_next = in_reg.first_byte ? '0 : dtype_reg;
        addr_next  = in_reg.first_byte ? '0 : addr_reg;
        attr_next  = in_reg.first_byte ? '0 : attr_reg;
        psl_next   = in_reg.first_byte ? '0 : psl_reg;
        done_next  = in_reg.first_byte ? 1'b0 : done_reg;
        bad_next   = in_reg.first_byte ? 1'b0 : bad_reg;
        in_ep_next   = in_ep_reg;
        in_pkt_next  = in_pkt_reg;
        out_ep_next  = out_ep_reg;
        out_pkt_next = out_pkt_reg;

        limit    = (total_next < BUF_LIMIT) ? total_next : BUF_LIMIT;
        limit_hi = ({b, total_next[7:0]} < BUF_LIMIT) ? {b, total_next[7:0]} : BUF_LIMIT;
        off      = pos - start_next;
        desc_end = {1'b0, pos} + {9'd0, b};
        do_open  = 1'b0;

        if (pos < BUF_LIMIT && !bad_next)
        begin
            if (pos == POS_TOTAL_LO)
            begin
                total_next[7:0] = b;
            end
            else if (pos == POS_TOTAL_HI)
            begin
                total_next[15:8] = b;
                if (start_next >= limit_hi)
                begin
                    done_next = 1'b1;
                end
            end
            else if (pos >= POS_FIRST_DESC)
            begin
                if (len_next == '0)
                begin
                    if (pos == start_next && !done_next)
                    begin
                        do_open = 1'b1;
                    end
                end
                else if (pos > start_next)
                begin
                    if (off == {8'd0, len_next})
                    begin
                        if (!done_next)
                        begin
                            do_open = 1'b1;
                        end
                        else
                        begin
                            len_next = '0;
                        end
                    end
                    else if (off < {8'd0, len_next})
                    begin
                        case (off)
                            OFF_TYPE:       dtype_next = b;
                            OFF_ADDRESS:    addr_next  = b;
                            OFF_ATTRIBUTES: attr_next  = b;
                            OFF_PACKET_LO:  psl_next   = b;
                            OFF_PACKET_HI:
                            begin
                                if (dtype_next == DESC_TYPE_ENDPOINT &&
                                    (attr_next & ATTR_TYPE_MASK) == ATTR_TYPE_BULK)
                                begin
                                    if (addr_next[ADDR_DIR_BIT])
                                    begin
                                        in_ep_next  = 4'(addr_next & ADDR_NUMBER_MASK);
                                        in_pkt_next = {b, psl_next};
                                    end
                                    else
                                    begin
                                        out_ep_next  = 4'(addr_next & ADDR_NUMBER_MASK);
                                        out_pkt_next = {b, psl_next};
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
        end

        if (do_open)
        begin
            start_next = pos;
            dtype_next = '0;
            addr_next  = '0;
            attr_next  = '0;
            psl_next   = '0;
            len_next   = b;
            if (b == '0)
            begin
                bad_next = 1'b1;
            end
            else if (desc_end >= {1'b0, limit})
            begin
                done_next = 1'b1;
            end
        end

        pos_next = (pos == POS_MAX) ? pos : pos + 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            total_reg     <= '0;
            start_reg     <= POS_FIRST_DESC;
            len_reg       <= '0;
            dtype_reg     <= '0;
            addr_reg      <= '0;
            attr_reg      <= '0;
            psl_reg       <= '0;
            in_ep_reg     <= '0;
            in_pkt_reg    <= RESET_PACKET;
            out_ep_reg    <= '0;
            out_pkt_reg   <= RESET_PACKET;
            done_reg      <= 1'b0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end

            if (take)
            begin
                pos_reg     <= pos_next;
                total_reg   <= total_next;
                start_reg   <= start_next;
                len_reg     <= len_next;
                dtype_reg   <= dtype_next;
                addr_reg    <= addr_next;
                attr_reg    <= attr_next;
                psl_reg     <= psl_next;
                in_ep_reg   <= in_ep_next;
                in_pkt_reg  <= in_pkt_next;
                out_ep_reg  <= out_ep_next;
                out_pkt_reg <= out_pkt_next;
                done_reg    <= done_next;
                bad_reg     <= bad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_reg <= item;
        end
        if (take)
        begin
            out_reg.in_endpoint    <= in_ep_next;
            out_reg.in_max_packet  <= in_pkt_next;
            out_reg.out_endpoint   <= out_ep_next;
            out_reg.out_max_packet <= out_pkt_next;
            out_reg.scan_done      <= done_next;
            out_reg.malformed      <= bad_next;
        end
    end

endmodule

[sim/ucdscan_check_pkg.sv]
// ----------------------------------------------------------------------------
// ucdscan_check_pkg
// Scoreboard for the endpoint scanner. It keeps its own copy of the
// descriptor walk and the bulk endpoints found so far. It works out the
// expected result for each accepted item and compares the results that
// arrive against them, in order and field by field.
// ----------------------------------------------------------------------------
package ucdscan_check_pkg;

    import ucdscan_pkg::*;

    class endpoint_scan_scoreboard;

        bit [15:0]   byte_pos;
        bit [15:0]   set_length;
        bit [15:0]   desc_start;
        bit [7:0]    desc_len;
        bit [7:0]    desc_type;
        bit [7:0]    ep_addr;
        bit [7:0]    ep_attr;
        bit [7:0]    packet_lo;
        bit [3:0]    in_ep;
        bit [15:0]   in_packet;
        bit [3:0]    out_ep;
        bit [15:0]   out_packet;
        bit          done_f;
        bit          malformed_f;
        result_t     expected_endpoints[$];
        int unsigned mismatches;

        function new();
            restart_walk();
            in_ep       = '0;
            in_packet   = RESET_PACKET;
            out_ep      = '0;
            out_packet  = RESET_PACKET;
            mismatches  = 0;
        endfunction

        function void restart_walk();
            byte_pos    = '0;
            set_length  = '0;
            desc_start  = POS_FIRST_DESC;
            desc_len    = '0;
            desc_type   = '0;
            ep_addr     = '0;
            ep_attr     = '0;
            packet_lo   = '0;
            done_f      = 1'b0;
            malformed_f = 1'b0;
        endfunction

        function int unsigned walk_limit();
            return (set_length < BUFFER_BYTES) ? set_length : BUFFER_BYTES;
        endfunction

        function void enter_descriptor(bit [15:0] pos, bit [7:0] len);
            desc_start = pos;
            desc_type  = '0;
            ep_addr    = '0;
            ep_attr    = '0;
            packet_lo  = '0;
            desc_len   = len;
            if (len == 0)
                malformed_f = 1'b1;
            else if (32'(pos) + 32'(len) >= walk_limit())
                done_f = 1'b1;
        endfunction

        function void absorb_byte(bit [15:0] pos, bit [7:0] b);
            bit [15:0] off;
            if (pos >= BUFFER_BYTES || malformed_f)
                return;
            if (pos == POS_TOTAL_LO)
            begin
                set_length[7:0] = b;
                return;
            end
            if (pos == POS_TOTAL_HI)
            begin
                set_length[15:8] = b;
                if (desc_start >= walk_limit())
                    done_f = 1'b1;
                return;
            end
            if (pos < POS_FIRST_DESC)
                return;
            if (desc_len == 0)
            begin
                if (pos == desc_start && !done_f)
                    enter_descriptor(pos, b);
                return;
            end
            if (pos <= desc_start)
                return;
            off = pos - desc_start;
            if (off == desc_len)
            begin
                if (!done_f)
                    enter_descriptor(pos, b);
                else
                    desc_len = '0;
                return;
            end
            if (off > desc_len)
                return;
            case (off)
                OFF_TYPE:       desc_type = b;
                OFF_ADDRESS:    ep_addr   = b;
                OFF_ATTRIBUTES: ep_attr   = b;
                OFF_PACKET_LO:  packet_lo = b;
                OFF_PACKET_HI:
                    if (desc_type == DESC_TYPE_ENDPOINT &&
                        (ep_attr & ATTR_TYPE_MASK) == ATTR_TYPE_BULK)
                    begin
                        if (ep_addr[ADDR_DIR_BIT])
                        begin
                            in_ep     = 4'(ep_addr & ADDR_NUMBER_MASK);
                            in_packet = {b, packet_lo};
                        end
                        else
                        begin
                            out_ep     = 4'(ep_addr & ADDR_NUMBER_MASK);
                            out_packet = {b, packet_lo};
                        end
                    end
                default: ;
            endcase
        endfunction

        function void note_item(item_t it);
            result_t want;
            if (it.first_byte)
                restart_walk();
            absorb_byte(byte_pos, it.data_byte);
            if (byte_pos != POS_MAX)
                byte_pos++;
            want.in_endpoint    = in_ep;
            want.in_max_packet  = in_packet;
            want.out_endpoint   = out_ep;
            want.out_max_packet = out_packet;
            want.scan_done      = done_f;
            want.malformed      = malformed_f;
            expected_endpoints.push_back(want);
        endfunction

        function void report_miss(string field, logic [15:0] want, logic [15:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", field, want, got);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_endpoints.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %p arrived with nothing expected", got);
                return;
            end
            want = expected_endpoints.pop_front();
            if (got.in_endpoint !== want.in_endpoint)
                report_miss("in_endpoint", want.in_endpoint, got.in_endpoint);
            if (got.in_max_packet !== want.in_max_packet)
                report_miss("in_max_packet", want.in_max_packet, got.in_max_packet);
            if (got.out_endpoint !== want.out_endpoint)
                report_miss("out_endpoint", want.out_endpoint, got.out_endpoint);
            if (got.out_max_packet !== want.out_max_packet)
                report_miss("out_max_packet", want.out_max_packet, got.out_max_packet);
            if (got.scan_done !== want.scan_done)
                report_miss("scan_done", want.scan_done, got.scan_done);
            if (got.malformed !== want.malformed)
                report_miss("malformed", want.malformed, got.malformed);
        endfunction

        function int unsigned pending();
            return expected_endpoints.size();
        endfunction

    endclass

endpackage

[sim/usb_config_descriptor_endpoint_scan_top_test.sv]
// ----------------------------------------------------------------------------
// usb_config_descriptor_endpoint_scan_top_test
// Drives descriptor sets byte by byte into the endpoint scanner: a short
// directed opening, then mostly well-formed sets with random content, cut
// and restarted sets and noise, and last a run of plain bytes that carries
// the byte position on past the end of the set. Both channels idle at
// random, except over one calm stretch.
// ----------------------------------------------------------------------------
module usb_config_descriptor_endpoint_scan_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ucdscan_pkg::*;
    import ucdscan_check_pkg::*;

    localparam int unsigned IDLE_PCT       = 6;
    localparam int unsigned RANDOM_ITEMS   = 1100;
    localparam int unsigned CALM_FROM      = 500;
    localparam int unsigned CALM_TO        = 850;
    localparam int unsigned LONG_RUN_ITEMS = 120;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned CYCLE_LIMIT    = 20000;
    localparam logic [7:0]  DESC_TYPE_INTERFACE = 8'h04;

    logic    clk;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    bit          calm = 1'b0;
    int unsigned items_sent = 0;
    int unsigned cycles = 0;
    logic [7:0]  set_bytes[$];

    endpoint_scan_scoreboard sb = new();

    usb_config_descriptor_endpoint_scan_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (result_valid && !result_stall)
            sb.check_result(result);
        result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic send_item(input item_t next_item);
        bit quiet;
        quiet = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);
        calm <= quiet;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= next_item;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(next_item);
        items_sent++;
    endtask

    task automatic send_set(input int unsigned count, input bit mark_first,
                            input int unsigned restart_pct);
        item_t next_item;
        for (int unsigned i = 0; i < count; i++)
        begin
            next_item.data_byte  = set_bytes[i];
            next_item.first_byte = (i == 0 && mark_first) ||
                                   ($urandom_range(99) < restart_pct);
            send_item(next_item);
        end
    endtask

    function automatic void build_set(bit oversize);
        logic [7:0]  desc[8];
        int unsigned count;
        int unsigned len;
        int unsigned pick;
        int unsigned total;
        bit          stop;
        set_bytes.delete();
        for (int i = 0; i < 9; i++)
            set_bytes.push_back(8'($urandom));
        set_bytes[0] = 8'h09;
        set_bytes[1] = 8'h02;
        count = oversize ? 45 : $urandom_range(1, 5);
        stop  = 1'b0;
        for (int n = 0; n < count && !stop; n++)
        begin
            pick = $urandom_range(99);
            foreach (desc[k])
                desc[k] = 8'($urandom);
            if (pick < 60)
            begin
                desc[1] = DESC_TYPE_ENDPOINT;
                if ($urandom_range(3) != 0)
                    desc[3][1:0] = ATTR_TYPE_BULK[1:0];
                len = ($urandom_range(7) == 0) ? $urandom_range(1, 12) : 7;
            end
            else if (pick < 85)
            begin
                desc[1] = DESC_TYPE_INTERFACE;
                len = 9;
            end
            else if (pick < 96 || oversize)
                len = $urandom_range(1, 12);
            else
            begin
                len  = 0;
                stop = 1'b1;
                set_bytes.push_back(8'h00);
            end
            desc[0] = 8'(len);
            for (int unsigned i = 0; i < len; i++)
                set_bytes.push_back(i < 8 ? desc[i] : 8'($urandom));
        end
        total = set_bytes.size();
        pick  = $urandom_range(99);
        if (!oversize)
        begin
            if (pick < 10)
                total = $urandom_range(0, 8);
            else if (pick < 25)
                total = $urandom_range(9, total);
            else if (pick < 40)
                total = total + $urandom_range(1, 16);
            else if (pick < 45)
                total = $urandom_range(0, 65535);
        end
        while (set_bytes.size() < total && set_bytes.size() < 300)
            set_bytes.push_back(8'($urandom));
        set_bytes[2] = total[7:0];
        set_bytes[3] = total[15:8];
    endfunction

    task automatic run_directed();
        // no restart after reset; bulk IN endpoint closes the set
        set_bytes = '{8'h09, 8'h02, 8'h10, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'hFA,
                      8'h07, 8'h05, 8'h81, 8'h02, 8'hFF, 8'hFF, 8'h00};
        send_set(set_bytes.size(), 1'b0, 0);
        // zero descriptor length, then a byte that must be dropped
        set_bytes = '{8'h09, 8'h02, 8'h20, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h07};
        send_set(set_bytes.size(), 1'b1, 0);
        // total length below nine
        set_bytes = '{8'h09, 8'h02, 8'h05, 8'h00};
        send_set(set_bytes.size(), 1'b1, 0);
    endtask

    task automatic run_random();
        int unsigned start;
        int unsigned sets;
        int unsigned pick;
        start = items_sent;
        sets  = 0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                build_set(sets % 20 == 7);
                send_set(set_bytes.size(), 1'b1, 0);
            end
            else if (pick < 90)
            begin
                build_set(1'b0);
                send_set($urandom_range(1, set_bytes.size()), 1'($urandom_range(1)), 3);
            end
            else
            begin
                set_bytes.delete();
                repeat ($urandom_range(1, 24))
                    set_bytes.push_back(8'($urandom));
                send_set(set_bytes.size(), 1'b0, 8);
            end
            sets++;
        end
    endtask

    task automatic run_long_count();
        item_t next_item;
        build_set(1'b0);
        send_set(set_bytes.size(), 1'b1, 0);
        next_item.first_byte = 1'b0;
        repeat (LONG_RUN_ITEMS)
        begin
            next_item.data_byte = 8'($urandom);
            send_item(next_item);
        end
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        run_long_count();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
